/* rtl/arpc_pkg.sv */
// arpc_pkg: shared types, widths and protocol constants of the ARP responder and cache
package arpc_pkg;

	localparam int CACHE_DEPTH_DEF = 128;
	localparam int MAC_W           = 48;
	localparam int IP_W            = 32;
	localparam int CFG_W           = 48;
	localparam int REG_IDX_W       = 1;
	localparam int OUTC_W          = 3;

	// register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_OWN_IP  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_OWN_MAC = 1'b1;

	// header field values, network order
	localparam logic [10:0] MIN_PKT_LEN = 11'd28;
	localparam logic [15:0] HTYPE_ETH   = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  HLEN_ETH    = 8'd6;
	localparam logic [7:0]  PLEN_IPV4   = 8'd4;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [15:0] OP_REPLY    = 16'd2;

	// outcome codes
	localparam logic [OUTC_W-1:0] OUTC_DROPPED    = 3'd0;
	localparam logic [OUTC_W-1:0] OUTC_REPLY      = 3'd1;
	localparam logic [OUTC_W-1:0] OUTC_LEARNED    = 3'd2;
	localparam logic [OUTC_W-1:0] OUTC_NOT_STORED = 3'd3;
	localparam logic [OUTC_W-1:0] OUTC_HIT        = 3'd4;
	localparam logic [OUTC_W-1:0] OUTC_MISS       = 3'd5;

	typedef struct packed {
		logic              mode;
		logic [10:0]       packet_length;
		logic [15:0]       hw_type;
		logic [15:0]       protocol_type;
		logic [7:0]        hw_addr_len;
		logic [7:0]        proto_addr_len;
		logic [15:0]       opcode;
		logic [MAC_W-1:0]  sender_mac;
		logic [IP_W-1:0]   sender_ip;
		logic [MAC_W-1:0]  target_mac;
		logic [IP_W-1:0]   target_ip;
		logic [IP_W-1:0]   query_ip;
	} arpc_in_t;

	typedef struct packed {
		logic [OUTC_W-1:0] outcome;
		logic [MAC_W-1:0]  reply_target_mac;
		logic [IP_W-1:0]   reply_target_ip;
		logic [MAC_W-1:0]  reply_sender_mac;
		logic [IP_W-1:0]   reply_sender_ip;
		logic [MAC_W-1:0]  found_mac;
	} arpc_out_t;

	// packet decision handed from the receive checker to the top level
	typedef struct packed {
		logic      learn;
		arpc_out_t res;
	} arpc_rx_t;

	// lookup token passed along the row of cache cells
	typedef struct packed {
		logic             valid;
		logic             hit;
		logic [MAC_W-1:0] mac;
	} arpc_tok_t;

endpackage

/* rtl/arpc_rx.sv */
// arpc_rx: header checks and reply or learn decision for a received ARP packet
module arpc_rx (
	input  arpc_pkg::arpc_in_t        item,
	input  logic [arpc_pkg::IP_W-1:0]  own_ip,
	input  logic [arpc_pkg::MAC_W-1:0] own_mac,
	input  logic                       full,
	output arpc_pkg::arpc_rx_t         rx
);
	import arpc_pkg::*;

	logic hdr_ok;

	assign hdr_ok = (item.packet_length >= MIN_PKT_LEN)
		&& (item.hw_type == HTYPE_ETH)
		&& (item.protocol_type == PTYPE_IPV4)
		&& (item.hw_addr_len == HLEN_ETH)
		&& (item.proto_addr_len == PLEN_IPV4)
		&& (item.target_ip == own_ip);

	always_comb begin
		rx = '0;
		rx.res.outcome = OUTC_DROPPED;
		if (hdr_ok) begin
			if (item.opcode == OP_REQUEST) begin
				rx.res.outcome          = OUTC_REPLY;
				rx.res.reply_target_mac = item.sender_mac;
				rx.res.reply_target_ip  = item.sender_ip;
				rx.res.reply_sender_mac = own_mac;
				rx.res.reply_sender_ip  = own_ip;
			end else if (item.opcode == OP_REPLY) begin
				if (full) begin
					rx.res.outcome = OUTC_NOT_STORED;
				end else begin
					rx.res.outcome = OUTC_LEARNED;
					rx.learn       = 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/arpc_cell.sv */
// arpc_cell: one cache entry and one stage of the lookup token chain
module arpc_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       learn,
	input  logic [CNT_W-1:0]           count,
	input  logic [arpc_pkg::IP_W-1:0]  wr_ip,
	input  logic [arpc_pkg::MAC_W-1:0] wr_mac,
	input  logic [arpc_pkg::IP_W-1:0]  query_ip,
	input  arpc_pkg::arpc_tok_t        tok_in,
	output arpc_pkg::arpc_tok_t        tok_out
);
	import arpc_pkg::*;

	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic             valid_q;
	logic             hit_q;
	logic [MAC_W-1:0] tmac_q;
	logic             in_range;
	logic             match;

	assign in_range = CNT_W'(INDEX) < count;
	assign match    = tok_in.valid && !tok_in.hit && in_range && (ip_q == query_ip);

	// entry store, filled when this cell is the next free slot
	always_ff @(posedge clk) begin
		if (learn && (count == CNT_W'(INDEX))) begin
			ip_q  <= wr_ip;
			mac_q <= wr_mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q  <= tok_in.hit || match;
		tmac_q <= match ? mac_q : tok_in.mac;
	end

	assign tok_out = '{valid: valid_q, hit: hit_q, mac: tmac_q};

endmodule

/* rtl/arp_responder_with_cache_top.sv */
// arp_responder_with_cache_top: ARP packet responder with an append-only address cache
//
// A packet item (mode 0) gives its result with done high in the cycle after the transfer
// of start. A lookup (mode 1) walks a row of CACHE_DEPTH cells, one cell per cycle, and
// gives its result once the token leaves the last cell; busy is high for the whole walk and
// start is ignored meanwhile. Each result is shown for one cycle only and must be taken
// then. Learned entries go into the next free cell; once CACHE_DEPTH entries are held,
// further replies are reported as not stored. No clearing pass follows reset.
module arp_responder_with_cache_top #(
	parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  arpc_pkg::arpc_in_t             cmd,
	output logic                           busy,
	input  logic                           wr_en,
	input  logic [arpc_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [arpc_pkg::CFG_W-1:0]     wr_data,
	output logic                           done,
	output arpc_pkg::arpc_out_t            result
);
	import arpc_pkg::*;

	localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;
	logic [CNT_W-1:0] count_q;
	logic [IP_W-1:0]  query_q;
	logic             busy_q;
	logic             done_q;
	arpc_out_t        res_q;
	arpc_tok_t        inj_q;
	arpc_tok_t        tok [0:CACHE_DEPTH];
	arpc_rx_t         rx;
	arpc_out_t        lk_res;
	logic             accept;
	logic             pkt_go;
	logic             lookup_go;
	logic             learn;
	logic             full;

	assign accept    = start && !busy_q;
	assign pkt_go    = accept && !cmd.mode;
	assign lookup_go = accept && cmd.mode;
	assign full      = count_q == CNT_W'(CACHE_DEPTH);
	assign learn     = pkt_go && rx.learn;

	arpc_rx u_rx (
		.item    (cmd),
		.own_ip  (own_ip_q),
		.own_mac (own_mac_q),
		.full    (full),
		.rx      (rx)
	);

	assign tok[0] = inj_q;

	for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
		arpc_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.learn    (learn),
			.count    (count_q),
			.wr_ip    (cmd.sender_ip),
			.wr_mac   (cmd.sender_mac),
			.query_ip (query_q),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	always_comb begin
		lk_res           = '0;
		lk_res.outcome   = tok[CACHE_DEPTH].hit ? OUTC_HIT : OUTC_MISS;
		lk_res.found_mac = tok[CACHE_DEPTH].hit ? tok[CACHE_DEPTH].mac : '1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OWN_IP:  own_ip_q  <= wr_data[IP_W-1:0];
				REG_OWN_MAC: own_mac_q <= wr_data[MAC_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			inj_q   <= '0;
		end else begin
			if (learn) begin
				count_q <= count_q + CNT_W'(1);
			end
			inj_q.valid <= lookup_go;
			inj_q.hit   <= 1'b0;
			inj_q.mac   <= '0;
			if (lookup_go) begin
				busy_q <= 1'b1;
			end else if (tok[CACHE_DEPTH].valid) begin
				busy_q <= 1'b0;
			end
			done_q <= pkt_go || tok[CACHE_DEPTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_go) begin
			query_q <= cmd.query_ip;
		end
		if (pkt_go) begin
			res_q <= rx.res;
		end else if (tok[CACHE_DEPTH].valid) begin
			res_q <= lk_res;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;

endmodule

/* rtl/arpc_checker.sv */
// arpc_checker: port-level assertions on the ARP responder, bound to the top level
module arpc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input arpc_pkg::arpc_in_t  cmd,
	input logic                done,
	input arpc_pkg::arpc_out_t result
);
	import arpc_pkg::*;

	// packet transfer gives its result in the next cycle
	a_pkt_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cmd.mode |=> done)
		else $error("packet result missing");

	// lookup transfer makes the block busy without an immediate result
	a_lk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.mode |=> busy && !done)
		else $error("lookup did not start");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("lookup ended without result");

	a_outc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.outcome <= OUTC_MISS)
		else $error("bad outcome code");

	a_reply_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.outcome != OUTC_REPLY |->
			result.reply_target_mac == '0 && result.reply_target_ip == '0
			&& result.reply_sender_mac == '0 && result.reply_sender_ip == '0)
		else $error("reply fields set without reply");

endmodule

bind arp_responder_with_cache_top arpc_checker u_arpc_checker (.*);
